// ===== rtl/core/bfa_pkg.sv =====
// Shared constants, word types and state codes of the first-fit block allocator.
package bfa_pkg;

    // Memory geometry
    localparam int NUM_BLOCKS      = 256;
    localparam int BLOCK_BYTES     = 4096;
    localparam int RESERVED_BLOCKS = 16;

    // Field widths
    localparam int SIZE_W  = 21;
    localparam int ADDR_W  = 20;
    localparam int USED_W  = 11;
    localparam int CNT_W   = 9;
    localparam int BLK_W   = $clog2(NUM_BLOCKS);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int NEED_W  = SIZE_W + 1 - BLOCK_SHIFT;

    // Used counter in KiB
    localparam int KIB_PER_BLOCK = BLOCK_BYTES / 1024;
    localparam int KIB_SHIFT     = $clog2(KIB_PER_BLOCK);
    localparam int KIB_W         = NEED_W + KIB_SHIFT;
    localparam int USED_MAX      = (1 << USED_W) - 1;

    // Bitmap sweep: a group of bits per cycle
    localparam int GRP_BITS   = 4;
    localparam int SUB_W      = $clog2(GRP_BITS);
    localparam int NUM_GROUPS = NUM_BLOCKS / GRP_BITS;
    localparam int GRP_W      = $clog2(NUM_GROUPS);

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Reset contents
    localparam logic [NUM_BLOCKS-1:0] RESET_MAP =
        {{(NUM_BLOCKS - RESERVED_BLOCKS){1'b0}}, {RESERVED_BLOCKS{1'b1}}};
    localparam logic [USED_W-1:0] RESET_USED = USED_W'(RESERVED_BLOCKS * KIB_PER_BLOCK);
    localparam logic [CNT_W-1:0]  RESET_FREE = CNT_W'(NUM_BLOCKS - RESERVED_BLOCKS);

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_ALLOC    = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [1:0] STAT_FREED    = 2'd2;
    localparam logic [1:0] STAT_NULL     = 2'd3;

    // Request word
    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    // Result word
    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] alloc_address;
        logic [USED_W-1:0] used_kib;
        logic [CNT_W-1:0]  free_count;
    } rsp_t;

    // Classified operation
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_ALLOC_FAIL,
        OP_FREE,
        OP_FREE_NULL
    } op_e;

    typedef struct packed {
        op_e               code;
        logic [NEED_W-1:0] need;
        logic [BLK_W-1:0]  first;
    } op_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_SWEEP,
        ST_RESP
    } back_state_e;

endpackage

// ===== rtl/core/bitmap_first_fit_block_allocator.sv =====
// Sequence from accepting a word to the result register: a null free, a zero-size free and a
// zero or oversized allocate go straight to the result; an allocate scans the map group by group
// of four bits up to the group that completes the run (all 64 groups when none fits), then marks
// each group the run spans; a free sweeps each group of four blocks it touches.
// Throughput: one request at a time; the back end takes the next word after a result is written.
// Reset: asynchronous, clears queue and result valid; map holds the low reserved blocks as used.
module bitmap_first_fit_block_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bfa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bfa_pkg::rsp_t rsp
);
    import bfa_pkg::*;

    op_t  front_op;
    op_t  head_op;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign req_stall = q_full;

    // Classify incoming word
    bfa_front u_front (
        .req (req),
        .op  (front_op)
    );

    // Decoupling queue
    bfa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (req_valid && !q_full),
        .push_op (front_op),
        .pop     (q_pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Map owner and result register
    bfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_op      (head_op),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/core/bfa_front.sv =====
// Front end: rounds the size to blocks and classifies each request word.
module bfa_front (
    input  bfa_pkg::req_t req,
    output bfa_pkg::op_t  op
);
    import bfa_pkg::*;

    logic [SIZE_W:0]   size_round;
    logic [NEED_W-1:0] need;

    // Round up to whole blocks
    assign size_round = {1'b0, req.size_bytes} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
    assign need       = size_round[SIZE_W:BLOCK_SHIFT];

    // Classify
    always_comb
    begin
        op.need  = need;
        op.first = req.free_address[ADDR_W-1 -: BLK_W];
        if (req.kind == KIND_ALLOC)
        begin
            if ((need == '0) || (need > NEED_W'(NUM_BLOCKS)))
                op.code = OP_ALLOC_FAIL;
            else
                op.code = OP_ALLOC;
        end
        else
        begin
            if (req.free_address == '0)
                op.code = OP_FREE_NULL;
            else
                op.code = OP_FREE;
        end
    end

endmodule

// ===== rtl/core/bfa_queue.sv =====
// Short queue of classified operations between front and back end.
module bfa_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bfa_pkg::op_t  push_op,
    input  logic          pop,
    output bfa_pkg::op_t  head_op,
    output logic          full,
    output logic          empty
);
    import bfa_pkg::*;

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full    = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

// ===== rtl/core/bfa_back.sv =====
// Back end: owns the block map and counters, runs the scan, mark and free sweeps.
module bfa_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  bfa_pkg::op_t  q_op,
    output logic          q_pop,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bfa_pkg::rsp_t rsp
);
    import bfa_pkg::*;

    back_state_e          state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [NUM_BLOCKS-1:0] map_reg, map_next;
    logic [USED_W-1:0]    used_reg, used_next;
    logic [CNT_W-1:0]     free_reg, free_next;
    logic [GRP_W-1:0]     grp_reg, grp_next;
    logic [CNT_W-1:0]     run_reg, run_next;
    logic [BLK_W-1:0]     start_reg, start_next;
    logic [BLK_W-1:0]     end_reg, end_next;
    logic [CNT_W-1:0]     lim_reg, lim_next;
    logic [1:0]           status_reg, status_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    // Scan and sweep results for the current group
    logic                 scan_found;
    logic [CNT_W-1:0]     scan_run;
    logic [BLK_W-1:0]     scan_start;
    logic [BLK_W-1:0]     scan_end;
    logic [NUM_BLOCKS-1:0] sweep_map;
    logic [SUB_W:0]       sweep_cnt;
    logic [NUM_BLOCKS-1:0] mark_map;
    logic [GRP_W-1:0]     end_grp;
    logic [CNT_W-1:0]     lim_last;
    logic [GRP_W-1:0]     last_grp;
    logic                 rsp_slot_free;

    // Arithmetic on the queued operation
    logic [KIB_W-1:0]     q_kib;
    logic [KIB_W-1:0]     cur_kib;
    logic [KIB_W:0]       used_add;
    logic [NEED_W:0]      q_end;
    logic [CNT_W-1:0]     q_lim;

    assign q_kib    = KIB_W'(q_op.need) << KIB_SHIFT;
    assign cur_kib  = KIB_W'(op_reg.need) << KIB_SHIFT;
    assign used_add = (KIB_W + 1)'(used_reg) + (KIB_W + 1)'(cur_kib);
    assign q_end    = (NEED_W + 1)'(q_op.first) + (NEED_W + 1)'(q_op.need);
    assign q_lim    = (q_end > (NEED_W + 1)'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                          : CNT_W'(q_end);
    assign lim_last = lim_reg - 1'b1;
    assign last_grp = lim_last[BLK_W-1:SUB_W];
    assign end_grp  = end_reg[BLK_W-1:SUB_W];
    assign rsp_slot_free = !rsp_valid_reg || !rsp_stall;

    // First-fit run search over one group of blocks
    always_comb
    begin
        logic [BLK_W-1:0] idx;
        scan_found = 1'b0;
        scan_run   = run_reg;
        scan_start = start_reg;
        scan_end   = end_reg;
        for (int k = 0; k < GRP_BITS; k++)
        begin
            idx = {grp_reg, SUB_W'(k)};
            if (!scan_found)
            begin
                if (!map_reg[idx])
                begin
                    if (scan_run == '0)
                        scan_start = idx;
                    scan_run = scan_run + 1'b1;
                    if ((NEED_W)'(scan_run) == op_reg.need)
                    begin
                        scan_found = 1'b1;
                        scan_end   = idx;
                    end
                end
                else
                    scan_run = '0;
            end
        end
    end

    // Set the blocks of one group that fall inside the granted run
    always_comb
    begin
        logic [BLK_W-1:0] idx;
        mark_map = map_reg;
        for (int k = 0; k < GRP_BITS; k++)
        begin
            idx = {grp_reg, SUB_W'(k)};
            if ((idx >= start_reg) && (idx <= end_reg))
                mark_map[idx] = 1'b1;
        end
    end

    // Clear used blocks of one group that fall inside the free range
    always_comb
    begin
        logic [BLK_W-1:0] idx;
        sweep_map = map_reg;
        sweep_cnt = '0;
        for (int k = 0; k < GRP_BITS; k++)
        begin
            idx = {grp_reg, SUB_W'(k)};
            if ((idx >= op_reg.first) && (CNT_W'(idx) < lim_reg) && map_reg[idx])
            begin
                sweep_map[idx] = 1'b0;
                sweep_cnt      = sweep_cnt + 1'b1;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_op.code)
                        OP_ALLOC: state_next = ST_SCAN;
                        OP_FREE:
                        begin
                            if (q_op.need == '0)
                                state_next = ST_RESP;
                            else
                                state_next = ST_SWEEP;
                        end
                        default:  state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_found)
                    state_next = ST_MARK;
                else if (grp_reg == GRP_W'(NUM_GROUPS - 1))
                    state_next = ST_RESP;
            end
            ST_MARK:
            begin
                if (grp_reg == end_grp)
                    state_next = ST_RESP;
            end
            ST_SWEEP:
            begin
                if (grp_reg == last_grp)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (rsp_slot_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        q_pop          = 1'b0;
        op_next        = op_reg;
        map_next       = map_reg;
        used_next      = used_reg;
        free_next      = free_reg;
        grp_next       = grp_reg;
        run_next       = run_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        lim_next       = lim_reg;
        status_next    = status_reg;
        addr_next      = addr_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_op;
                    addr_next = '0;
                    run_next  = '0;
                    case (q_op.code)
                        OP_ALLOC:
                        begin
                            grp_next = '0;
                        end
                        OP_ALLOC_FAIL:
                        begin
                            status_next = STAT_NO_SPACE;
                        end
                        OP_FREE:
                        begin
                            status_next = STAT_FREED;
                            grp_next    = q_op.first[BLK_W-1:SUB_W];
                            lim_next    = q_lim;
                            // used counter drops by the requested size, floor at zero
                            if (q_kib >= KIB_W'(used_reg))
                                used_next = '0;
                            else
                                used_next = used_reg - USED_W'(q_kib);
                        end
                        default:
                        begin
                            status_next = STAT_NULL;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                run_next   = scan_run;
                start_next = scan_start;
                end_next   = scan_end;
                // on a hit, go back to the group where the run starts
                if (scan_found)
                    grp_next = scan_start[BLK_W-1:SUB_W];
                else
                    grp_next = grp_reg + 1'b1;
                if (!scan_found && (grp_reg == GRP_W'(NUM_GROUPS - 1)))
                    status_next = STAT_NO_SPACE;
            end
            ST_MARK:
            begin
                map_next = mark_map;
                grp_next = grp_reg + 1'b1;
                // counters and address once the last group of the run is set
                if (grp_reg == end_grp)
                begin
                    free_next   = free_reg - CNT_W'(op_reg.need);
                    status_next = STAT_ALLOC;
                    addr_next   = ADDR_W'(start_reg) << BLOCK_SHIFT;
                    if (used_add > (KIB_W + 1)'(USED_MAX))
                        used_next = USED_W'(USED_MAX);
                    else
                        used_next = USED_W'(used_add);
                end
            end
            ST_SWEEP:
            begin
                map_next  = sweep_map;
                free_next = free_reg + CNT_W'(sweep_cnt);
                grp_next  = grp_reg + 1'b1;
            end
            ST_RESP:
            begin
                if (rsp_slot_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.status        = status_reg;
                    rsp_next.alloc_address = addr_reg;
                    rsp_next.used_kib      = used_reg;
                    rsp_next.free_count    = free_reg;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Control and map registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            map_reg       <= RESET_MAP;
            used_reg      <= RESET_USED;
            free_reg      <= RESET_FREE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            map_reg       <= map_next;
            used_reg      <= used_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        grp_reg    <= grp_next;
        run_reg    <= run_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        lim_reg    <= lim_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
